FILE: rtl/euler_to_quaternion_defines.svh
// Assertion macros used by the euler_to_quaternion top level.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define E2Q_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("e2q same-cycle check failed");
// Next-cycle implication.
`define E2Q_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("e2q next-cycle check failed");
`else
`define E2Q_ASSERT_IMP(label, clk, rst_n, pre, post)
`define E2Q_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

FILE: rtl/e2q_pkg.sv
// Shared types and constants for the Euler angle to quaternion converter.
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

	localparam int ANGLE_WIDTH = 16;
	localparam int QUAT_WIDTH  = 16;

	// Angles live in a 32-bit turn where the full word is one revolution.
	localparam int TURN_WIDTH   = 32;
	localparam int CS_WIDTH     = 32;
	localparam int CS_FRAC      = TURN_WIDTH - 2;
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_WIDTH   = $clog2(CORDIC_STEPS);

	localparam int COMBINE_STAGES = 4;
	localparam int PIPE_DEPTH     = CORDIC_STEPS + COMBINE_STAGES;

	localparam int PROD_WIDTH  = 2 * CS_WIDTH;
	localparam int SUM_WIDTH   = PROD_WIDTH + 2;
	localparam int ROUND_SHIFT = 2 * CS_FRAC + 1 - QUAT_WIDTH;

	localparam logic signed [CS_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

	localparam logic signed [CS_WIDTH-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5,
		32'sd3, 32'sd1
	};

	// Rounding offsets and saturation bounds used by the combine stages.
	localparam logic signed [PROD_WIDTH-1:0] MUL_HALF =
		PROD_WIDTH'(64'sd1 <<< (CS_FRAC - 1));
	localparam logic signed [SUM_WIDTH-1:0] SUM_HALF =
		SUM_WIDTH'(64'sd1 <<< (ROUND_SHIFT - 1));
	localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
		SUM_WIDTH'((64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUM_WIDTH-1:0] SAT_LO =
		SUM_WIDTH'(-(64'sd1 <<< (QUAT_WIDTH - 1)));

	typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
	typedef logic signed [QUAT_WIDTH-1:0]  quat_comp_t;
	typedef logic signed [CS_WIDTH-1:0]    cs_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic [STEP_WIDTH-1:0]         step_t;

	typedef struct packed {
		cs_t cos_v;
		cs_t sin_v;
	} sincos_t;

	typedef struct packed {
		quat_comp_t w;
		quat_comp_t x;
		quat_comp_t y;
		quat_comp_t z;
	} quat_t;

endpackage
`default_nettype wire

FILE: rtl/e2q_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic_cell (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire e2q_pkg::step_t step,
	input  wire e2q_pkg::cs_t   atan,
	input  wire e2q_pkg::cs_t   x_in,
	input  wire e2q_pkg::cs_t   y_in,
	input  wire e2q_pkg::cs_t   z_in,
	output e2q_pkg::cs_t        x_q,
	output e2q_pkg::cs_t        y_q,
	output e2q_pkg::cs_t        z_q
);

	e2q_pkg::cs_t dx;
	e2q_pkg::cs_t dy;

	// Floor shifts of the neighbor coordinate.
	assign dx = y_in >>> step;
	assign dy = x_in >>> step;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[e2q_pkg::CS_WIDTH-1]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - atan;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + atan;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/e2q_cordic_row.sv
// Row of CORDIC cells that turns one angle into cosine and sine of its half.
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic_row (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire e2q_pkg::angle_t angle,
	output e2q_pkg::sincos_t     sincos
);

	e2q_pkg::cs_t x_w [e2q_pkg::CORDIC_STEPS+1];
	e2q_pkg::cs_t y_w [e2q_pkg::CORDIC_STEPS+1];
	e2q_pkg::cs_t z_w [e2q_pkg::CORDIC_STEPS+1];
	e2q_pkg::cs_t turn;

	// Place the angle at the top of the turn word, then halve it.
	assign turn = e2q_pkg::TURN_WIDTH'(angle) <<< (e2q_pkg::TURN_WIDTH - e2q_pkg::ANGLE_WIDTH);

	assign x_w[0] = e2q_pkg::CORDIC_GAIN;
	assign y_w[0] = '0;
	assign z_w[0] = turn >>> 1;

	for (genvar i = 0; i < e2q_pkg::CORDIC_STEPS; i++) begin : g_cell
		e2q_cordic_cell u_cell (
			.clk  (clk),
			.en   (en),
			.step (e2q_pkg::STEP_WIDTH'(i)),
			.atan (e2q_pkg::ATAN_TURNS[i]),
			.x_in (x_w[i]),
			.y_in (y_w[i]),
			.z_in (z_w[i]),
			.x_q  (x_w[i+1]),
			.y_q  (y_w[i+1]),
			.z_q  (z_w[i+1])
		);
	end

	assign sincos.cos_v = x_w[e2q_pkg::CORDIC_STEPS];
	assign sincos.sin_v = y_w[e2q_pkg::CORDIC_STEPS];

endmodule
`default_nettype wire

FILE: rtl/e2q_combine.sv
// Four-stage product pipeline that forms the quaternion from the half-angle sines and cosines.
`timescale 1ns / 1ps
`default_nettype none
module e2q_combine (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire e2q_pkg::sincos_t sc1,
	input  wire e2q_pkg::sincos_t sc2,
	input  wire e2q_pkg::sincos_t sc3,
	output e2q_pkg::quat_t        quat_s4
);

	// Stage 1: pairwise products of the first two angles.
	e2q_pkg::prod_t p_c1c2_s1, p_s1s2_s1, p_s1c2_s1, p_c1s2_s1;
	e2q_pkg::cs_t   c3_s1, s3_s1;
	// Stage 2: pairwise products rounded back to Q2.30.
	e2q_pkg::cs_t   c1c2_s2, s1s2_s2, s1c2_s2, c1s2_s2;
	e2q_pkg::cs_t   c3_s2, s3_s2;
	// Stage 3: the eight full products.
	e2q_pkg::prod_t a_s3, b_s3, c_s3, d_s3, e_s3, f_s3, g_s3, h_s3;

	function automatic e2q_pkg::cs_t round_pair(input e2q_pkg::prod_t p);
		e2q_pkg::prod_t r;
		r = p + e2q_pkg::MUL_HALF;
		return e2q_pkg::CS_WIDTH'(r >>> e2q_pkg::CS_FRAC);
	endfunction

	function automatic e2q_pkg::quat_comp_t finish(input e2q_pkg::prod_t a,
	                                               input e2q_pkg::prod_t b,
	                                               input logic sub);
		logic signed [e2q_pkg::SUM_WIDTH-1:0] s;
		logic signed [e2q_pkg::SUM_WIDTH-1:0] v;
		if (sub) begin
			s = e2q_pkg::SUM_WIDTH'(a) - e2q_pkg::SUM_WIDTH'(b);
		end else begin
			s = e2q_pkg::SUM_WIDTH'(a) + e2q_pkg::SUM_WIDTH'(b);
		end
		v = (s + e2q_pkg::SUM_HALF) >>> e2q_pkg::ROUND_SHIFT;
		// Most values are already in range, so neither bound applies to them.
		if (v > e2q_pkg::SAT_HI) begin
			v = e2q_pkg::SAT_HI;
		end else if (v < e2q_pkg::SAT_LO) begin
			v = e2q_pkg::SAT_LO;
		end
		return e2q_pkg::QUAT_WIDTH'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			p_c1c2_s1 <= sc1.cos_v * sc2.cos_v;
			p_s1s2_s1 <= sc1.sin_v * sc2.sin_v;
			p_s1c2_s1 <= sc1.sin_v * sc2.cos_v;
			p_c1s2_s1 <= sc1.cos_v * sc2.sin_v;
			c3_s1     <= sc3.cos_v;
			s3_s1     <= sc3.sin_v;

			c1c2_s2 <= round_pair(p_c1c2_s1);
			s1s2_s2 <= round_pair(p_s1s2_s1);
			s1c2_s2 <= round_pair(p_s1c2_s1);
			c1s2_s2 <= round_pair(p_c1s2_s1);
			c3_s2   <= c3_s1;
			s3_s2   <= s3_s1;

			a_s3 <= c1c2_s2 * c3_s2;
			b_s3 <= s1s2_s2 * s3_s2;
			c_s3 <= c1c2_s2 * s3_s2;
			d_s3 <= s1s2_s2 * c3_s2;
			e_s3 <= s1c2_s2 * c3_s2;
			f_s3 <= c1s2_s2 * s3_s2;
			g_s3 <= c1s2_s2 * c3_s2;
			h_s3 <= s1c2_s2 * s3_s2;

			quat_s4.w <= finish(a_s3, b_s3, 1'b1);
			quat_s4.x <= finish(c_s3, d_s3, 1'b0);
			quat_s4.y <= finish(e_s3, f_s3, 1'b0);
			quat_s4.z <= finish(g_s3, h_s3, 1'b1);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/euler_to_quaternion.sv
// Top level of the Euler angle to unit quaternion converter.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_stall, heading/pitch/roll_angle   | into block
//   out     | out_valid, out_stall, quat_w/x/y/z             | out of block
//
// One transaction enters per cycle while nothing stalls, and its result passes through
// 30 CORDIC cells per angle, 4 combine stages and 1 output register.
// The sustained rate is one transaction per cycle while nothing stalls, set by the
// cell rows and the combine pipeline, which each take a new operand set every enabled cycle.
// Reset clears only the valid bits of the pipeline, output and skid registers.
// A stall at the output is absorbed by a one-entry skid register; only when
// that is also full does the whole pipeline freeze and in_stall rise.
`timescale 1ns / 1ps
`default_nettype none
`include "euler_to_quaternion_defines.svh"
module euler_to_quaternion (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire e2q_pkg::angle_t     heading_angle,
	input  wire e2q_pkg::angle_t     pitch_angle,
	input  wire e2q_pkg::angle_t     roll_angle,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output e2q_pkg::quat_comp_t      quat_w,
	output e2q_pkg::quat_comp_t      quat_x,
	output e2q_pkg::quat_comp_t      quat_y,
	output e2q_pkg::quat_comp_t      quat_z
);

	localparam int LAST = e2q_pkg::PIPE_DEPTH - 1;

	logic                             pipe_en;
	logic [e2q_pkg::PIPE_DEPTH-1:0]   valid_pipe_q;
	e2q_pkg::sincos_t                 sc_heading, sc_pitch, sc_roll;
	e2q_pkg::quat_t                   quat_s4;
	e2q_pkg::quat_t                   out_data_q;
	e2q_pkg::quat_t                   skid_data_q;
	logic                             out_valid_q;
	logic                             skid_valid_q;
	logic                             out_fire;

	// The pipeline moves whenever the skid register is free; it is the only
	// place a finished transaction can be parked besides the output register.
	assign pipe_en  = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign out_fire = out_valid_q && !out_stall;

	// Heading, attitude and bank each get their own row of cells.
	e2q_cordic_row u_row_heading (
		.clk    (clk),
		.en     (pipe_en),
		.angle  (heading_angle),
		.sincos (sc_heading)
	);

	e2q_cordic_row u_row_pitch (
		.clk    (clk),
		.en     (pipe_en),
		.angle  (pitch_angle),
		.sincos (sc_pitch)
	);

	e2q_cordic_row u_row_roll (
		.clk    (clk),
		.en     (pipe_en),
		.angle  (roll_angle),
		.sincos (sc_roll)
	);

	e2q_combine u_combine (
		.clk     (clk),
		.en      (pipe_en),
		.sc1     (sc_heading),
		.sc2     (sc_pitch),
		.sc3     (sc_roll),
		.quat_s4 (quat_s4)
	);

	// Valid bits travel alongside the data, one per pipeline register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_pipe_q <= '0;
		end else if (pipe_en) begin
			valid_pipe_q <= {valid_pipe_q[LAST-1:0], in_valid};
		end
	end

	// Output register plus skid register. When the skid holds a transaction
	// the pipeline is frozen, so the last stage is never looked at twice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_fire) begin
					skid_valid_q <= 1'b0;
				end
			end else if (valid_pipe_q[LAST]) begin
				if (out_valid_q && !out_fire) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_data_q <= skid_data_q;
			end
		end else if (valid_pipe_q[LAST]) begin
			if (out_valid_q && !out_fire) begin
				skid_data_q <= quat_s4;
			end else begin
				out_data_q <= quat_s4;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign quat_w    = out_data_q.w;
	assign quat_x    = out_data_q.x;
	assign quat_y    = out_data_q.y;
	assign quat_z    = out_data_q.z;

	// A parked transaction always has one ahead of it in the output register.
	`E2Q_ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	// A finished transaction meeting a stalled output must be parked.
	`E2Q_ASSERT_NXT(a_park_on_stall, clk, arst_n, out_valid_q && out_stall && !skid_valid_q && valid_pipe_q[LAST], skid_valid_q)
	// The skid stays full while the output is stalled.
	`E2Q_ASSERT_NXT(a_skid_holds, clk, arst_n, skid_valid_q && out_stall, skid_valid_q)
	// Every accepted transaction enters the first pipeline stage.
	`E2Q_ASSERT_NXT(a_accept_enters, clk, arst_n, in_valid && !in_stall, valid_pipe_q[0])

endmodule
`default_nettype wire
